// ===== rtl/rv32ex_pkg.sv =====
// Shared types and constants for the RV32I execute stage.
// Instruction kind codes, memory access codes and the execute result record.
package rv32ex_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned REG_W = 5;
  localparam int unsigned KIND_W = 6;

  typedef enum logic [KIND_W-1:0] {
    K_LUI, K_AUIPC, K_JAL, K_JALR,
    K_BEQ, K_BNE, K_BLT, K_BGE, K_BLTU, K_BGEU,
    K_LB, K_LH, K_LW, K_LBU, K_LHU,
    K_SB, K_SH, K_SW,
    K_ADDI, K_SLTI, K_SLTIU, K_XORI, K_ORI, K_ANDI, K_SLLI, K_SRLI, K_SRAI,
    K_ADD, K_SUB, K_SLL, K_SLT, K_SLTU, K_XOR, K_SRL, K_SRA, K_OR, K_AND,
    K_HALT
  } kind_e;

  typedef enum logic [1:0] {
    MEM_NONE,
    MEM_LD,
    MEM_ST
  } mem_kind_e;

  typedef enum logic [1:0] {
    SIZE_BYTE,
    SIZE_HALF,
    SIZE_WORD
  } mem_size_e;

  localparam logic [XLEN-1:0] PC_STEP = XLEN'(4);
  localparam logic [XLEN-1:0] JALR_MASK = 32'hFFFF_FFFE;
  localparam logic [XLEN-1:0] BYTE_MASK = 32'h0000_00FF;
  localparam logic [XLEN-1:0] HALF_MASK = 32'h0000_FFFF;

  typedef struct packed {
    logic             writes_reg;
    logic [REG_W-1:0] dest_reg;
    logic [XLEN-1:0]  result_value;
    logic             jumps;
    logic             is_branch;
    logic             br_taken;
    logic [XLEN-1:0]  next_target;
    mem_kind_e        mem_kind;
    mem_size_e        mem_size;
    logic             load_sext;
    logic [XLEN-1:0]  mem_address;
    logic             halt_seen;
  } exec_result_t;

endpackage

// ===== rtl/rv32i_execute_unit_core.sv =====
// Top level of the RV32I execute stage: operand register, execute logic and
// result register with valid/ready on both sides. Depends on rv32ex_pkg, rv32ex_alu.

// One instruction enters per clock when the output side keeps up; each
// instruction is captured in the operand register, goes through a single
// combinational pass of rv32ex_alu and is captured in the result register,
// from which its result is presented; a stalled consumer can hold it in either.
// When the result register is held by a stalled consumer, the operand register
// still takes one more transaction before in_ready_o drops. No state survives
// between instructions, and there are no configuration registers.
module rv32i_execute_unit_core import rv32ex_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [KIND_W-1:0] ins_kind_i,
  input  logic [XLEN-1:0]   ins_pc_i,
  input  logic [XLEN-1:0]   immediate_i,
  input  logic [XLEN-1:0]   first_operand_i,
  input  logic [XLEN-1:0]   second_operand_i,
  input  logic [REG_W-1:0]  dest_index_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              writes_reg_o,
  output logic [REG_W-1:0]  dest_reg_o,
  output logic [XLEN-1:0]   result_value_o,
  output logic              jumps_o,
  output logic              is_branch_o,
  output logic              br_taken_o,
  output logic [XLEN-1:0]   next_target_o,
  output logic [1:0]        mem_kind_o,
  output logic [1:0]        mem_size_o,
  output logic              load_sext_o,
  output logic [XLEN-1:0]   mem_address_o,
  output logic              halt_seen_o
);

  logic              op_valid_q;
  logic [KIND_W-1:0] kind_q;
  logic [XLEN-1:0]   pc_q;
  logic [XLEN-1:0]   imm_q;
  logic [XLEN-1:0]   op_a_q;
  logic [XLEN-1:0]   op_b_q;
  logic [REG_W-1:0]  rd_q;

  logic              res_valid_q;
  exec_result_t      res_q;
  exec_result_t      res_d;

  logic              res_load;
  logic              op_load;

  // advance the operand register whenever the result register is free
  assign res_load   = !res_valid_q || out_ready_i;
  assign in_ready_o = !op_valid_q || res_load;
  assign op_load    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      op_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_load) begin
      kind_q <= ins_kind_i;
      pc_q   <= ins_pc_i;
      imm_q  <= immediate_i;
      op_a_q <= first_operand_i;
      op_b_q <= second_operand_i;
      rd_q   <= dest_index_i;
    end
  end

  rv32ex_alu u_alu (
    .kind_i (kind_q),
    .pc_i   (pc_q),
    .imm_i  (imm_q),
    .op_a_i (op_a_q),
    .op_b_i (op_b_q),
    .rd_i   (rd_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= op_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load && op_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign writes_reg_o   = res_q.writes_reg;
  assign dest_reg_o     = res_q.dest_reg;
  assign result_value_o = res_q.result_value;
  assign jumps_o        = res_q.jumps;
  assign is_branch_o    = res_q.is_branch;
  assign br_taken_o     = res_q.br_taken;
  assign next_target_o  = res_q.next_target;
  assign mem_kind_o     = res_q.mem_kind;
  assign mem_size_o     = res_q.mem_size;
  assign load_sext_o    = res_q.load_sext;
  assign mem_address_o  = res_q.mem_address;
  assign halt_seen_o    = res_q.halt_seen;

  // backpressure only when both registers are full and the consumer stalls
  a_ready_low_only_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (op_valid_q && out_valid_o && !out_ready_i)
  ) else $error("input stalled while a register was free");

  a_no_write_on_branch_store: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (is_branch_o || mem_kind_o == MEM_ST))
      |-> (!writes_reg_o && dest_reg_o == '0)
  ) else $error("branch or store claims a register write");

  a_jump_branch_exclusive: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(jumps_o && is_branch_o) && (!br_taken_o || is_branch_o)
  ) else $error("inconsistent control-flow flags");

  a_result_moves_forward: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (op_valid_q && res_load) |=> out_valid_o
  ) else $error("operand transaction lost on advance");

endmodule

// ===== rtl/rv32ex_alu.sv =====
// Combinational execute logic: ALU, branch resolution, jump targets and
// memory access decode for one instruction. Depends on rv32ex_pkg.
module rv32ex_alu import rv32ex_pkg::*; (
  input  logic [KIND_W-1:0] kind_i,
  input  logic [XLEN-1:0]   pc_i,
  input  logic [XLEN-1:0]   imm_i,
  input  logic [XLEN-1:0]   op_a_i,
  input  logic [XLEN-1:0]   op_b_i,
  input  logic [REG_W-1:0]  rd_i,
  output exec_result_t      res_o
);

  logic [XLEN-1:0] addr;
  logic [XLEN-1:0] pc_plus4;
  logic [XLEN-1:0] pc_plus_imm;
  logic [XLEN-1:0] alu_b;
  logic [4:0]      shamt;
  logic [XLEN-1:0] alu_out;
  logic            lt_s;
  logic            lt_u;
  logic            cond;
  logic            is_reg_op;

  assign addr        = op_a_i + imm_i;
  assign pc_plus4    = pc_i + PC_STEP;
  assign pc_plus_imm = pc_i + imm_i;
  assign is_reg_op   = (kind_i inside {[K_ADD:K_AND]});
  assign alu_b       = is_reg_op ? op_b_i : imm_i;
  assign shamt       = alu_b[4:0];
  assign lt_s        = $signed(op_a_i) < $signed(alu_b);
  assign lt_u        = op_a_i < alu_b;

  always_comb begin
    case (kind_i)
      K_ADDI, K_ADD:   alu_out = op_a_i + alu_b;
      K_SUB:           alu_out = op_a_i - alu_b;
      K_SLTI, K_SLT:   alu_out = {{(XLEN-1){1'b0}}, lt_s};
      K_SLTIU, K_SLTU: alu_out = {{(XLEN-1){1'b0}}, lt_u};
      K_XORI, K_XOR:   alu_out = op_a_i ^ alu_b;
      K_ORI, K_OR:     alu_out = op_a_i | alu_b;
      K_ANDI, K_AND:   alu_out = op_a_i & alu_b;
      K_SLLI, K_SLL:   alu_out = op_a_i << shamt;
      K_SRLI, K_SRL:   alu_out = op_a_i >> shamt;
      default:         alu_out = XLEN'($signed(op_a_i) >>> shamt);
    endcase
  end

  // branch compares use rs2 directly
  always_comb begin
    case (kind_i)
      K_BEQ:   cond = (op_a_i == op_b_i);
      K_BNE:   cond = (op_a_i != op_b_i);
      K_BLT:   cond = $signed(op_a_i) < $signed(op_b_i);
      K_BGE:   cond = !($signed(op_a_i) < $signed(op_b_i));
      K_BLTU:  cond = op_a_i < op_b_i;
      default: cond = op_a_i >= op_b_i;
    endcase
  end

  always_comb begin
    res_o              = '0;
    res_o.dest_reg     = rd_i;
    res_o.mem_kind     = MEM_NONE;
    res_o.mem_size     = SIZE_BYTE;
    res_o.mem_address  = addr;
    if (kind_i == K_LUI) begin
      res_o.writes_reg   = 1'b1;
      res_o.result_value = imm_i;
    end else if (kind_i == K_AUIPC) begin
      res_o.writes_reg   = 1'b1;
      res_o.result_value = pc_plus_imm;
    end else if (kind_i == K_JAL) begin
      res_o.writes_reg   = 1'b1;
      res_o.jumps        = 1'b1;
      res_o.result_value = pc_plus4;
      res_o.next_target  = pc_plus_imm;
    end else if (kind_i == K_JALR) begin
      res_o.writes_reg   = 1'b1;
      res_o.jumps        = 1'b1;
      res_o.result_value = pc_plus4;
      res_o.next_target  = addr & JALR_MASK;
    end else if (kind_i inside {[K_BEQ:K_BGEU]}) begin
      res_o.is_branch    = 1'b1;
      res_o.dest_reg     = '0;
      res_o.br_taken     = cond;
      res_o.next_target  = cond ? pc_plus_imm : pc_plus4;
    end else if (kind_i inside {[K_LB:K_LHU]}) begin
      res_o.writes_reg = 1'b1;
      res_o.mem_kind   = MEM_LD;
      if (kind_i == K_LB || kind_i == K_LBU) begin
        res_o.mem_size = SIZE_BYTE;
      end else if (kind_i == K_LW) begin
        res_o.mem_size = SIZE_WORD;
      end else begin
        res_o.mem_size = SIZE_HALF;
      end
      res_o.load_sext = (kind_i == K_LB || kind_i == K_LH);
    end else if (kind_i inside {[K_SB:K_SW]}) begin
      res_o.mem_kind = MEM_ST;
      res_o.dest_reg = '0;
      // mask store data to the access size
      if (kind_i == K_SB) begin
        res_o.mem_size     = SIZE_BYTE;
        res_o.result_value = op_b_i & BYTE_MASK;
      end else if (kind_i == K_SH) begin
        res_o.mem_size     = SIZE_HALF;
        res_o.result_value = op_b_i & HALF_MASK;
      end else begin
        res_o.mem_size     = SIZE_WORD;
        res_o.result_value = op_b_i;
      end
    end else if (kind_i inside {[K_ADDI:K_AND]}) begin
      res_o.writes_reg   = 1'b1;
      res_o.result_value = alu_out;
    end else if (kind_i == K_HALT) begin
      res_o.halt_seen = 1'b1;
    end
  end

endmodule
